// ===== sv/rfaq_pkg.sv =====
package rfaq_pkg;

  // field widths
  localparam int unsigned LEN_W    = 14;
  localparam int unsigned ETYPE_W  = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned HDR_W    = 8;
  localparam int unsigned QFILL_W  = 5;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  // stream packing: input tdata holds length, ethertype, time, limit
  localparam int unsigned IN_BITS  = LEN_W + ETYPE_W + TIME_W + LEN_W;
  localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = LEN_W + TIME_W + 4 * CNT_W + QFILL_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;

  localparam logic [ETYPE_W-1:0] ETYPE_MIN = 16'h0600;

  // configuration reset values
  localparam logic [LEN_W-1:0] MIN_FRAME_RST = 14'd60;
  localparam logic [LEN_W-1:0] MAX_FRAME_RST = 14'd1518;
  localparam logic [HDR_W-1:0] HEADER_RST    = 8'd14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_FRAME = 2'd0,
    CFG_MAX_FRAME = 2'd1,
    CFG_HEADER    = 2'd2
  } cfg_idx_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADMIT   = 2'd0,
    CMD_DELIVER = 2'd1,
    CMD_FLUSH   = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_LEN_REJECT  = 3'd1,
    ST_INVALID     = 3'd2,
    ST_DROP_FULL   = 3'd3,
    ST_DELIVERED   = 3'd4,
    ST_QUEUE_EMPTY = 3'd5
  } status_e;

  // one queued descriptor
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [LEN_W-1:0]  len;
  } desc_t;

  // queue operation request from the admit logic
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } fifo_op_t;

endpackage

// ===== sv/rfaq_desc_fifo.sv =====
module rfaq_desc_fifo import rfaq_pkg::*; #(
  parameter int unsigned QueueDepth = DEFAULT_QUEUE_DEPTH,
  localparam int unsigned PtrW  = $clog2(QueueDepth),
  localparam int unsigned FillW = $clog2(QueueDepth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fifo_op_t         op_i,
  input  desc_t            wdata_i,
  output desc_t            rdata_o,
  output logic             full_o,
  output logic             empty_o,
  output logic [FillW-1:0] fill_o
);

  desc_t            mem_q [QueueDepth];
  desc_t            rdata_q;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    next_slot = (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (fill_q == FillW'(QueueDepth));
  assign empty_o = (fill_q == '0);
  assign fill_o  = fill_q;
  assign rdata_o = rdata_q;

  // pointer and fill update, one operation per beat
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    if (op_i.flush) begin
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      fill_d   = '0;
    end else if (op_i.push) begin
      wr_ptr_d = next_slot(wr_ptr_q);
      fill_d   = fill_q + 1'b1;
    end else if (op_i.pop) begin
      rd_ptr_d = next_slot(rd_ptr_q);
      fill_d   = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // descriptor storage, write port
  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // registered read of the oldest entry, held until the next pop
  always_ff @(posedge clk_i) begin
    if (op_i.pop) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

endmodule

// ===== sv/rx_frame_admit_queue.sv =====
// channel   | direction | beat contents
// ----------+-----------+-----------------------------------------------------
// s_axis    | in        | command (tuser), frame length, ethertype, time, limit
// m_axis    | out       | status (tuser), length, time, 4 counters, queue fill
// cfg       | in        | register index and write data, always ready
//
// Each command beat is decoded and applied to the queue and counters at the
// edge it is accepted, and its result appears in the output register the
// next cycle. A beat can be accepted every cycle; the only limit is the
// single result register, so s_axis_tready follows m_axis_tready while a
// result is waiting. Reset clears the queue pointers, fill count and
// counters and loads the configuration defaults; no clearing pass is
// needed.
module rx_frame_admit_queue import rfaq_pkg::*; #(
  parameter int unsigned QueueDepth = DEFAULT_QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // command stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [13:0] frame_length, [29:14] ether_type, [61:30] arrival_time,
  // [75:62] deliver_limit, [79:76] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] command
  input  logic [CMD_W-1:0]       s_axis_tuser,
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [13:0] out_length, [45:14] out_time, [77:46] rx_pkt_count,
  // [109:78] rx_byte_count, [141:110] rx_err_count,
  // [173:142] rx_drop_count, [178:174] queue_fill, [183:179] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic [STATUS_W-1:0]    m_axis_tuser
);

  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  logic [LEN_W-1:0] min_frame_q;
  logic [LEN_W-1:0] max_frame_q;
  logic [HDR_W-1:0] header_q;

  logic [CNT_W-1:0] pkt_cnt_q, pkt_cnt_d;
  logic [CNT_W-1:0] byte_cnt_q, byte_cnt_d;
  logic [CNT_W-1:0] err_cnt_q, err_cnt_d;
  logic [CNT_W-1:0] drop_cnt_q, drop_cnt_d;

  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [LEN_W-1:0] limit_q;

  logic             in_beat;
  cmd_e             cmd;
  logic [LEN_W-1:0] in_len;
  logic [ETYPE_W-1:0] in_etype;
  logic [TIME_W-1:0]  in_time;
  logic [LEN_W-1:0]   in_limit;

  fifo_op_t         fifo_op;
  desc_t            wdesc;
  desc_t            rdesc;
  logic             fifo_full;
  logic             fifo_empty;
  logic [FillW-1:0] fifo_fill;

  logic [LEN_W-1:0]  out_len;
  logic [TIME_W-1:0] out_time;

  // input unpacking
  assign cmd      = cmd_e'(s_axis_tuser);
  assign in_len   = s_axis_tdata[LEN_W-1:0];
  assign in_etype = s_axis_tdata[LEN_W +: ETYPE_W];
  assign in_time  = s_axis_tdata[LEN_W + ETYPE_W +: TIME_W];
  assign in_limit = s_axis_tdata[LEN_W + ETYPE_W + TIME_W +: LEN_W];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_frame_q <= MIN_FRAME_RST;
      max_frame_q <= MAX_FRAME_RST;
      header_q    <= HEADER_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_FRAME: min_frame_q <= cfg_data_i[LEN_W-1:0];
        CFG_MAX_FRAME: max_frame_q <= cfg_data_i[LEN_W-1:0];
        CFG_HEADER:    header_q    <= cfg_data_i[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  // command decode, admit checks and counter updates
  always_comb begin
    fifo_op    = '0;
    status_d   = ST_OK;
    pkt_cnt_d  = pkt_cnt_q;
    byte_cnt_d = byte_cnt_q;
    err_cnt_d  = err_cnt_q;
    drop_cnt_d = drop_cnt_q;
    unique case (cmd)
      CMD_ADMIT: begin
        priority if (in_len == '0 || in_len > max_frame_q) begin
          status_d = ST_LEN_REJECT;
        end else if (in_len < min_frame_q ||
                     (in_len >= LEN_W'(header_q) && in_etype < ETYPE_MIN)) begin
          status_d  = ST_INVALID;
          err_cnt_d = err_cnt_q + 1'b1;
        end else if (fifo_full) begin
          status_d   = ST_DROP_FULL;
          drop_cnt_d = drop_cnt_q + 1'b1;
        end else begin
          status_d     = ST_OK;
          fifo_op.push = in_beat;
          pkt_cnt_d    = pkt_cnt_q + 1'b1;
          byte_cnt_d   = byte_cnt_q + CNT_W'(in_len);
        end
      end
      CMD_DELIVER: begin
        if (fifo_empty) begin
          status_d = ST_QUEUE_EMPTY;
        end else begin
          status_d    = ST_DELIVERED;
          fifo_op.pop = in_beat;
        end
      end
      CMD_FLUSH: begin
        fifo_op.flush = in_beat;
      end
      CMD_CLEAR: begin
        pkt_cnt_d  = '0;
        byte_cnt_d = '0;
        err_cnt_d  = '0;
        drop_cnt_d = '0;
      end
      default: ;
    endcase
  end

  assign wdesc.len   = in_len;
  assign wdesc.stamp = in_time;

  rfaq_desc_fifo #(
    .QueueDepth(QueueDepth)
  ) u_desc_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (fifo_op),
    .wdata_i (wdesc),
    .rdata_o (rdesc),
    .full_o  (fifo_full),
    .empty_o (fifo_empty),
    .fill_o  (fifo_fill)
  );

  // statistics counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_cnt_q  <= '0;
      byte_cnt_q <= '0;
      err_cnt_q  <= '0;
      drop_cnt_q <= '0;
    end else if (in_beat) begin
      pkt_cnt_q  <= pkt_cnt_d;
      byte_cnt_q <= byte_cnt_d;
      err_cnt_q  <= err_cnt_d;
      drop_cnt_q <= drop_cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      status_q <= status_d;
      limit_q  <= in_limit;
    end
  end

  // delivered length clamp on the registered descriptor
  always_comb begin
    out_len  = '0;
    out_time = '0;
    if (status_q == ST_DELIVERED) begin
      out_len  = (rdesc.len < limit_q) ? rdesc.len : limit_q;
      out_time = rdesc.stamp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0),
                          QFILL_W'(fifo_fill),
                          drop_cnt_q,
                          err_cnt_q,
                          byte_cnt_q,
                          pkt_cnt_q,
                          out_time,
                          out_len};

endmodule

// ===== test/rx_frame_admit_queue_tb.sv =====
`timescale 1ns / 100ps

module rx_frame_admit_queue_tb;
  import rfaq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  // one expected result beat
  typedef struct packed {
    status_e           status;
    logic [LEN_W-1:0]  olen;
    logic [TIME_W-1:0] otime;
    logic [CNT_W-1:0]  pkts;
    logic [CNT_W-1:0]  octets;
    logic [CNT_W-1:0]  errs;
    logic [CNT_W-1:0]  drops;
    logic [QFILL_W-1:0] fill;
  } rx_outcome_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  // shared run control
  bit gaps_on = 1'b1;
  int hold_cycles = 0;
  int fail_cnt = 0;
  int stall_cycles = 0;
  rx_outcome_t outcome_q[$];

  // shadow of the block state
  logic [LEN_W-1:0]  desc_len [QUEUE_DEPTH];
  logic [TIME_W-1:0] desc_time [QUEUE_DEPTH];
  logic [3:0] rd_ptr = '0;
  logic [3:0] wr_ptr = '0;
  int fill_lvl = 0;
  logic [CNT_W-1:0] pkt_cnt = '0;
  logic [CNT_W-1:0] byte_cnt = '0;
  logic [CNT_W-1:0] err_cnt = '0;
  logic [CNT_W-1:0] drop_cnt = '0;
  logic [LEN_W-1:0] cfg_min = MIN_FRAME_RST;
  logic [LEN_W-1:0] cfg_max = MAX_FRAME_RST;
  logic [HDR_W-1:0] cfg_hdr = HEADER_RST;

  rx_frame_admit_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // admission, delivery, flush and clear applied to the shadow state
  task automatic compute_admit_outcome(input cmd_e cmd, input logic [LEN_W-1:0] len,
                                       input logic [ETYPE_W-1:0] etype,
                                       input logic [TIME_W-1:0] stamp,
                                       input logic [LEN_W-1:0] limit);
    rx_outcome_t o;
    o = '0;
    o.status = ST_OK;
    case (cmd)
      CMD_ADMIT: begin
        if (len == '0 || len > cfg_max) begin
          o.status = ST_LEN_REJECT;
        end else if (len < cfg_min || (len >= LEN_W'(cfg_hdr) && etype < ETYPE_MIN)) begin
          err_cnt = err_cnt + 1;
          o.status = ST_INVALID;
        end else if (fill_lvl >= QUEUE_DEPTH) begin
          drop_cnt = drop_cnt + 1;
          o.status = ST_DROP_FULL;
        end else begin
          desc_len[wr_ptr] = len;
          desc_time[wr_ptr] = stamp;
          wr_ptr = wr_ptr + 1'b1;
          fill_lvl++;
          pkt_cnt = pkt_cnt + 1;
          byte_cnt = byte_cnt + CNT_W'(len);
        end
      end
      CMD_DELIVER: begin
        if (fill_lvl == 0) begin
          o.status = ST_QUEUE_EMPTY;
        end else begin
          o.olen = (desc_len[rd_ptr] < limit) ? desc_len[rd_ptr] : limit;
          o.otime = desc_time[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          fill_lvl--;
          o.status = ST_DELIVERED;
        end
      end
      CMD_FLUSH: begin
        rd_ptr = '0;
        wr_ptr = '0;
        fill_lvl = 0;
      end
      default: begin
        pkt_cnt = '0;
        byte_cnt = '0;
        err_cnt = '0;
        drop_cnt = '0;
      end
    endcase
    o.pkts = pkt_cnt;
    o.octets = byte_cnt;
    o.errs = err_cnt;
    o.drops = drop_cnt;
    o.fill = fill_lvl[QFILL_W-1:0];
    outcome_q.push_back(o);
  endtask

  // offer one command beat, with an occasional gap before it
  task automatic send_cmd(input cmd_e cmd, input logic [LEN_W-1:0] len,
                          input logic [ETYPE_W-1:0] etype, input logic [TIME_W-1:0] stamp,
                          input logic [LEN_W-1:0] limit);
    while (gaps_on && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'({limit, stamp, etype, len});
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    compute_admit_outcome(cmd, len, etype, stamp, limit);
  endtask

  // random fields for a command whose payload is ignored or arbitrary
  task automatic send_rand(input cmd_e cmd);
    send_cmd(cmd, LEN_W'($urandom()), ETYPE_W'($urandom()), $urandom(),
             LEN_W'($urandom()));
  endtask

  // admit a frame that passes the length checks where the limits allow it
  task automatic send_good_admit();
    logic [LEN_W-1:0] lo;
    logic [LEN_W-1:0] len;
    logic [ETYPE_W-1:0] etype;
    int r;
    lo = (cfg_min == '0) ? 14'd1 : cfg_min;
    if (lo <= cfg_max) len = LEN_W'($urandom_range(cfg_max, lo));
    else len = LEN_W'($urandom_range(16383, 1));
    r = $urandom_range(99);
    if (r < 80) etype = ETYPE_W'($urandom_range(16'hFFFF, ETYPE_MIN));
    else if (r < 88) etype = 16'h0806;
    else etype = ETYPE_W'($urandom_range(ETYPE_MIN - 16'd1, 0));
    send_cmd(CMD_ADMIT, len, etype, $urandom(), LEN_W'($urandom()));
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_results_settled();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  // register write, only called while the block is idle
  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MIN_FRAME: cfg_min = val;
      CFG_MAX_FRAME: cfg_max = val;
      default:       cfg_hdr = val[HDR_W-1:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [CFG_DATA_W-1:0] min_b,
                            input logic [CFG_DATA_W-1:0] max_b,
                            input logic [CFG_DATA_W-1:0] hdr_b);
    wait_results_settled();
    cfg_write(CFG_MIN_FRAME, min_b);
    cfg_write(CFG_MAX_FRAME, max_b);
    cfg_write(CFG_HEADER, hdr_b);
  endtask

  // mostly well-formed admits and delivers, with bursts that fill the queue
  task automatic run_traffic(input int n);
    int left;
    int r;
    int burst;
    left = n;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 4) begin
        burst = $urandom_range(24, 17);
        repeat (burst) send_good_admit();
        left -= burst;
      end else begin
        if (r < 7) send_rand(CMD_FLUSH);
        else if (r < 10) send_rand(CMD_CLEAR);
        else if (r < 52) send_good_admit();
        else if (r < 62) send_rand(CMD_ADMIT);
        else if (r < 81) send_rand(CMD_DELIVER);
        else send_cmd(CMD_DELIVER, LEN_W'($urandom()), ETYPE_W'($urandom()), $urandom(),
                      LEN_W'($urandom_range(cfg_max, 0)));
        left--;
      end
    end
  endtask

  task automatic test_directed_cases();
    send_cmd(CMD_DELIVER, 14'd0, 16'h0000, 32'h0, 14'h3FFF);
    send_cmd(CMD_ADMIT, 14'd0, 16'h0800, 32'h1, 14'd0);
    send_cmd(CMD_ADMIT, 14'd1519, 16'h0800, 32'h2, 14'd0);
    send_cmd(CMD_ADMIT, 14'd1518, 16'h0800, 32'hFFFF_FFFF, 14'd0);
    send_cmd(CMD_ADMIT, 14'd59, 16'h0800, 32'h3, 14'd0);
    send_cmd(CMD_ADMIT, 14'd60, ETYPE_MIN, 32'h0, 14'd0);
    send_cmd(CMD_ADMIT, 14'd64, ETYPE_MIN - 16'd1, 32'h4, 14'd0);
    send_cmd(CMD_ADMIT, 14'd64, 16'h0806, 32'hA5A5_5A5A, 14'd0);
    send_cmd(CMD_ADMIT, 14'h3FFF, 16'hFFFF, 32'h5, 14'h3FFF);
    // clamp above, to zero and just below the stored length
    send_cmd(CMD_DELIVER, 14'h3FFF, 16'hFFFF, 32'hFFFF_FFFF, 14'h3FFF);
    send_cmd(CMD_DELIVER, 14'd0, 16'h0, 32'h0, 14'd0);
    send_cmd(CMD_DELIVER, 14'd0, 16'h0, 32'h0, 14'd63);
    send_cmd(CMD_DELIVER, 14'd0, 16'h0, 32'h0, 14'd100);
    send_cmd(CMD_ADMIT, 14'd100, 16'h86DD, 32'h6, 14'd0);
    send_cmd(CMD_FLUSH, 14'd0, 16'h0, 32'h0, 14'd0);
    send_cmd(CMD_DELIVER, 14'd0, 16'h0, 32'h0, 14'h3FFF);
    send_cmd(CMD_CLEAR, 14'd0, 16'h0, 32'h0, 14'd0);
    // ethertype check only from the header length on
    set_limits(14'd0, 14'h3FFF, 14'd14);
    send_cmd(CMD_ADMIT, 14'd13, 16'h0000, 32'h7, 14'd0);
    send_cmd(CMD_ADMIT, 14'd14, 16'h0000, 32'h8, 14'd0);
    send_cmd(CMD_ADMIT, 14'h3FFF, ETYPE_MIN, 32'h9, 14'd0);
    send_cmd(CMD_DELIVER, 14'd0, 16'h0, 32'h0, 14'h3FFF);
    send_cmd(CMD_CLEAR, 14'd0, 16'h0, 32'h0, 14'd0);
    set_limits(MIN_FRAME_RST, MAX_FRAME_RST, CFG_DATA_W'(HEADER_RST));
  endtask

  // offer more admits than the queue holds, then as many delivers
  task automatic test_fill_and_drop();
    repeat (QUEUE_DEPTH + 2) send_good_admit();
    repeat (QUEUE_DEPTH + 2) send_rand(CMD_DELIVER);
    wait_results_settled();
  endtask

  task automatic test_random_traffic();
    set_limits(MIN_FRAME_RST, MAX_FRAME_RST, CFG_DATA_W'(HEADER_RST));
    run_traffic(150);
    // no idling on either side through this phase
    set_limits(14'd0, 14'h3FFF, 14'd0);
    gaps_on = 1'b0;
    run_traffic(200);
    wait_results_settled();
    gaps_on = 1'b1;
    set_limits(14'h3FFF, 14'h3FFF, 14'h3FFF);
    run_traffic(80);
    // minimum above maximum
    set_limits(14'd1000, 14'd500, 14'd14);
    run_traffic(60);
    repeat (2) begin
      set_limits(CFG_DATA_W'($urandom_range(200, 0)),
                 CFG_DATA_W'($urandom_range(16383, 64)),
                 CFG_DATA_W'($urandom_range(255, 0)));
      run_traffic(130);
    end
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    wait_results_settled();
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (40) begin
      if ($urandom_range(1)) send_good_admit();
      else send_rand(CMD_DELIVER);
    end
    wait_results_settled();
  endtask

  // result ready with random stalls and the counted hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(gaps_on && $urandom_range(99) < 8);
      end
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  // compare each result beat with the oldest expectation
  initial begin
    rx_outcome_t o;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          fail_cnt++;
          $display("%0t unexpected result beat: expected none actual status %0d",
                   $time, m_axis_tuser);
        end else begin
          o = outcome_q.pop_front();
          check_field("status", 32'(o.status), 32'(m_axis_tuser));
          check_field("out_length", 32'(o.olen), 32'(m_axis_tdata[LEN_W-1:0]));
          check_field("out_time", o.otime, m_axis_tdata[LEN_W +: TIME_W]);
          check_field("packets", o.pkts, m_axis_tdata[LEN_W+TIME_W +: CNT_W]);
          check_field("bytes", o.octets, m_axis_tdata[LEN_W+TIME_W+CNT_W +: CNT_W]);
          check_field("errors", o.errs, m_axis_tdata[LEN_W+TIME_W+2*CNT_W +: CNT_W]);
          check_field("dropped", o.drops, m_axis_tdata[LEN_W+TIME_W+3*CNT_W +: CNT_W]);
          check_field("queue_fill", 32'(o.fill),
                      32'(m_axis_tdata[LEN_W+TIME_W+4*CNT_W +: QFILL_W]));
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("[rx_frame_admit_queue] ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_fill_and_drop();
    test_random_traffic();
    test_backpressure();
    wait_results_settled();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && outcome_q.size() == 0) begin
      $display("[rx_frame_admit_queue] OK");
    end else begin
      $display("[rx_frame_admit_queue] ERROR");
    end
    $finish;
  end

endmodule
